// File: design/fia_pkg.sv
// Shared types, character codes and digit lookup for the integer formatter.
`timescale 1ns / 1ps
`default_nettype none

package fia_pkg;

    // Argument and conversion widths.
    localparam int ARG_W      = 32;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int IDX_W      = 4;
    localparam int CNT_W      = 5;

    // Character codes that steer the formatter.
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_DEC     = 8'h64;
    localparam logic [7:0] CH_HEX     = 8'h78;
    localparam logic [7:0] CH_MINUS   = 8'h2d;

    // Sequencer states of the top level.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_LEAD,
        ST_EMIT
    } t_state;

    // Maps one digit value to its lower-case ASCII character.
    function automatic logic [7:0] digit_char(input logic [3:0] nib);
        logic [7:0] ch;
        case (nib)
            4'h0: ch = 8'h30;
            4'h1: ch = 8'h31;
            4'h2: ch = 8'h32;
            4'h3: ch = 8'h33;
            4'h4: ch = 8'h34;
            4'h5: ch = 8'h35;
            4'h6: ch = 8'h36;
            4'h7: ch = 8'h37;
            4'h8: ch = 8'h38;
            4'h9: ch = 8'h39;
            4'ha: ch = 8'h61;
            4'hb: ch = 8'h62;
            4'hc: ch = 8'h63;
            4'hd: ch = 8'h64;
            4'he: ch = 8'h65;
            default: ch = 8'h66;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// File: design/fia_dabble.sv
// Iterative binary to BCD converter, one shift-and-correct step per cycle.
`timescale 1ns / 1ps
`default_nettype none

module fia_dabble (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [fia_pkg::ARG_W-1:0] i_value,
    output logic                           o_done,
    output logic [fia_pkg::BCD_W-1:0]      o_bcd
);

    logic [fia_pkg::ARG_W-1:0] r_bin;
    logic [fia_pkg::BCD_W-1:0] r_bcd;
    logic [fia_pkg::BCD_W-1:0] corr;
    logic [fia_pkg::CNT_W-1:0] r_cnt;
    logic                      r_busy;
    logic                      r_done;

    // Add three to every BCD digit of five or more before the next shift.
    always_comb begin
        for (int k = 0; k < fia_pkg::BCD_DIGITS; k++) begin
            if (r_bcd[4*k +: 4] >= 4'd5) begin
                corr[4*k +: 4] = r_bcd[4*k +: 4] + 4'd3;
            end else begin
                corr[4*k +: 4] = r_bcd[4*k +: 4];
            end
        end
    end

    // Control: one step per cycle for every bit of the argument.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= fia_pkg::CNT_W'(fia_pkg::ARG_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - fia_pkg::CNT_W'(1);
                end
            end
        end
    end

    // Datapath: shift the binary word into the corrected BCD register.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bin <= i_value;
            r_bcd <= '0;
        end else if (r_busy) begin
            r_bin <= {r_bin[fia_pkg::ARG_W-2:0], 1'b0};
            r_bcd <= {corr[fia_pkg::BCD_W-2:0], r_bin[fia_pkg::ARG_W-1]};
        end
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

`default_nettype wire

// File: design/format_int_to_ascii.sv
// Top level of the printf-style integer formatter: sequencer and output register.
//
// Usage: each input item carries one format-string byte and one 32-bit argument.
// An ordinary byte is echoed as one result item in the cycle after acceptance.
// A '%' byte arms a pending flag and produces nothing. The following byte is a
// specifier: 'd' prints the argument as signed decimal, 'x' as lower-case hex,
// both without leading zeros; any other specifier produces nothing.
// The last character caused by one input item carries o_run_last.
// Both channels use valid and stall; an item moves when valid is high and
// stall is low. o_stall is high during a conversion or emission, and also
// while a held result is stalled. Ordinary bytes stream at one per cycle
// while the receiver does not stall. A hex specifier passes acceptance and
// a leading-digit search, then emits one character per cycle while the
// receiver does not stall. A decimal specifier runs the BCD shift unit, one
// step per argument bit, after the accepting cycle, then collects the result
// and finds the leading digit, and emits characters in the same way.
// Reset clears the pending flag, the sequencer and the output valid flag.
// When the receiver stalls, the current result holds and emission pauses.
`timescale 1ns / 1ps
`default_nettype none

module format_int_to_ascii (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic [7:0]                i_fmt_byte,
    input  wire logic [fia_pkg::ARG_W-1:0] i_arg_value,
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output logic [7:0]                     o_out_char,
    output logic                           o_run_last
);

    fia_pkg::t_state r_state, n_state;
    logic r_pending, n_pending;
    logic r_neg, n_neg;
    logic [fia_pkg::BCD_W-1:0] r_digits, n_digits;
    logic [fia_pkg::IDX_W-1:0] r_idx, n_idx;
    logic r_out_valid, n_out_valid;
    logic [7:0] r_out_char, n_out_char;
    logic r_out_last, n_out_last;

    logic in_acc;
    logic slot_free;
    logic conv_start;
    logic conv_done;
    logic [fia_pkg::BCD_W-1:0] conv_bcd;
    logic [fia_pkg::ARG_W-1:0] magnitude;
    logic [fia_pkg::IDX_W-1:0] lead_idx;
    logic [3:0] cur_nib;

    assign o_stall   = (r_state != fia_pkg::ST_IDLE) || (r_out_valid && i_stall);
    assign in_acc    = i_valid && !o_stall;
    assign slot_free = !r_out_valid || !i_stall;
    assign magnitude = i_arg_value[fia_pkg::ARG_W-1] ?
                       fia_pkg::ARG_W'(0 - i_arg_value) : i_arg_value;
    assign cur_nib   = r_digits[{r_idx, 2'b00} +: 4];

    // Binary to BCD unit for the decimal specifier.
    fia_dabble u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (conv_start),
        .i_value (magnitude),
        .o_done  (conv_done),
        .o_bcd   (conv_bcd)
    );

    // Position of the most significant nonzero digit, zero when all are zero.
    always_comb begin
        lead_idx = '0;
        for (int k = 0; k < fia_pkg::BCD_DIGITS; k++) begin
            if (r_digits[4*k +: 4] != 4'h0) begin
                lead_idx = fia_pkg::IDX_W'(k);
            end
        end
    end

    // Sequencer: next state, digit buffer and output register loads.
    always_comb begin
        n_state     = r_state;
        n_pending   = r_pending;
        n_neg       = r_neg;
        n_digits    = r_digits;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        conv_start  = 1'b0;
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            fia_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (r_pending) begin
                        n_pending = 1'b0;
                        if (i_fmt_byte == fia_pkg::CH_DEC) begin
                            n_neg      = i_arg_value[fia_pkg::ARG_W-1];
                            conv_start = 1'b1;
                            n_state    = fia_pkg::ST_CONV;
                        end else if (i_fmt_byte == fia_pkg::CH_HEX) begin
                            n_neg    = 1'b0;
                            n_digits = fia_pkg::BCD_W'(i_arg_value);
                            n_state  = fia_pkg::ST_LEAD;
                        end
                    end else if (i_fmt_byte == fia_pkg::CH_PERCENT) begin
                        n_pending = 1'b1;
                    end else begin
                        n_out_valid = 1'b1;
                        n_out_char  = i_fmt_byte;
                        n_out_last  = 1'b1;
                    end
                end
            end
            fia_pkg::ST_CONV: begin
                if (conv_done) begin
                    n_digits = conv_bcd;
                    n_state  = fia_pkg::ST_LEAD;
                end
            end
            fia_pkg::ST_LEAD: begin
                n_idx   = lead_idx;
                n_state = fia_pkg::ST_EMIT;
            end
            fia_pkg::ST_EMIT: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    if (r_neg) begin
                        n_out_char = fia_pkg::CH_MINUS;
                        n_out_last = 1'b0;
                        n_neg      = 1'b0;
                    end else begin
                        n_out_char = fia_pkg::digit_char(cur_nib);
                        n_out_last = (r_idx == '0);
                        if (r_idx == '0) begin
                            n_state = fia_pkg::ST_IDLE;
                        end else begin
                            n_idx = r_idx - fia_pkg::IDX_W'(1);
                        end
                    end
                end
            end
            default: begin
                n_state = fia_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fia_pkg::ST_IDLE;
            r_pending   <= 1'b0;
            r_neg       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pending   <= n_pending;
            r_neg       <= n_neg;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_digits   <= n_digits;
        r_idx      <= n_idx;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    assign o_valid    = r_out_valid;
    assign o_out_char = r_out_char;
    assign o_run_last = r_out_last;

endmodule

`default_nettype wire
